// File: src/kems_pkg.sv
// shared types and constants for the k-mer exact match seeder
package kems_pkg;

    localparam int READ_LEN_DEF = 64;

    localparam int KMER_W  = 7;
    localparam int RLEN_W  = 7;
    localparam int RUN_W   = 7;
    localparam int POS_W   = 32;
    localparam int SYM_W   = 8;
    localparam int RIDX_W  = 6;
    localparam int OP_W    = 2;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 7;

    localparam logic [KMER_W-1:0] KMER_MAX   = 7'd64;
    localparam logic [KMER_W-1:0] KMER_RST   = 7'd16;
    localparam logic [RLEN_W-1:0] RLEN_RST   = 7'd64;
    localparam logic [SYM_W:0]    CASE_DELTA = 9'd32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_GENOME = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_KMER_LEN = 1'b0,
        CFG_READ_LEN = 1'b1
    } t_cfg_idx;

    // what travels with a hit mask to the seed emitter
    typedef struct packed {
        logic [RIDX_W-1:0] kmer_m1;
        logic [POS_W-1:0]  gpos_first;
    } t_batch_info;

endpackage

// File: src/kems_cells.sv
// read store, per-position run counters and genome position
module kems_cells
    import kems_pkg::*;
#(
    parameter int READ_LEN = READ_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KMER_W-1:0]   i_kmer_len,
    input  logic [RLEN_W-1:0]   i_read_len,
    input  logic                i_go,
    input  t_opcode             i_opcode,
    input  logic [RIDX_W-1:0]   i_read_index,
    input  logic [SYM_W-1:0]    i_symbol,
    output logic [READ_LEN-1:0] o_hit,
    output t_batch_info         o_info
);

    localparam logic [RLEN_W-1:0] RL_LIM = RLEN_W'(READ_LEN);

    logic [SYM_W-1:0] r_store [READ_LEN];
    logic [RUN_W-1:0] r_run   [READ_LEN];
    logic [RUN_W-1:0] n_run   [READ_LEN];
    logic [POS_W-1:0] r_pos;

    logic [KMER_W-1:0] s_k;
    logic [RLEN_W-1:0] s_used;
    logic              s_genome;

    always_comb begin
        if (i_kmer_len == '0) begin
            s_k = KMER_W'(1);
        end else if (i_kmer_len > KMER_MAX) begin
            s_k = KMER_MAX;
        end else begin
            s_k = i_kmer_len;
        end
        s_used   = (i_read_len > RL_LIM) ? RL_LIM : i_read_len;
        s_genome = (i_opcode == OP_GENOME);
    end

    genvar g;
    generate
        for (g = 0; g < READ_LEN; g++) begin : g_cell
            logic [RUN_W-1:0] s_prev;
            logic [RUN_W-1:0] s_inc;
            logic [SYM_W:0]   s_st;
            logic [SYM_W:0]   s_sy;
            logic             s_match;

            if (g == 0) begin : g_first
                assign s_prev = '0;
            end else begin : g_rest
                assign s_prev = r_run[g-1];
            end

            assign s_st    = {1'b0, r_store[g]};
            assign s_sy    = {1'b0, i_symbol};
            // equal, or CASE_DELTA apart (the letter case gap, for any byte), in used cells only
            assign s_match = (RLEN_W'(g) < s_used) &&
                             ((s_st == s_sy) || (s_st + CASE_DELTA == s_sy) ||
                              (s_sy + CASE_DELTA == s_st));
            assign s_inc   = s_prev + RUN_W'(1);
            assign o_hit[g] = s_genome && s_match && (s_inc >= s_k);
            assign n_run[g] = !s_match ? '0 : ((s_inc >= s_k) ? s_k : s_inc);

            always_ff @(posedge i_clk) begin
                if (i_go && i_opcode == OP_LOAD && i_read_index == RIDX_W'(g)) begin
                    r_store[g] <= i_symbol;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_run[g] <= '0;
                end else if (i_go && i_opcode == OP_CLEAR) begin
                    r_run[g] <= '0;
                end else if (i_go && s_genome) begin
                    r_run[g] <= n_run[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_go && i_opcode == OP_CLEAR) begin
            r_pos <= '0;
        end else if (i_go && s_genome) begin
            r_pos <= r_pos + POS_W'(1);
        end
    end

    always_comb begin
        o_info.kmer_m1    = RIDX_W'(s_k - KMER_W'(1));
        o_info.gpos_first = r_pos - POS_W'(o_info.kmer_m1);
    end

endmodule

// File: src/kems_emit.sv
// holds one hit mask and sends its seeds in rising read order
module kems_emit
    import kems_pkg::*;
#(
    parameter int READ_LEN = READ_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [READ_LEN-1:0] i_hit,
    input  t_batch_info         i_info,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RIDX_W-1:0]   o_seed_ridx,
    output logic [POS_W-1:0]    o_seed_gpos,
    output logic                o_last
);

    logic [READ_LEN-1:0] r_mask;
    t_batch_info         r_info;
    logic [READ_LEN-1:0] s_low;
    logic [READ_LEN-1:0] s_rest;
    logic [RIDX_W-1:0]   s_pos;

    // isolate the lowest pending hit, then encode it by or-ing indexes
    always_comb begin
        s_low  = r_mask & (~r_mask + READ_LEN'(1));
        s_rest = r_mask & ~s_low;
        s_pos  = '0;
        for (int i = 0; i < READ_LEN; i++) begin
            if (s_low[i]) begin
                s_pos = s_pos | RIDX_W'(i);
            end
        end
    end

    assign o_valid     = |r_mask;
    assign o_last      = (s_rest == '0);
    assign o_seed_ridx = s_pos - r_info.kmer_m1;
    assign o_seed_gpos = r_info.gpos_first;
    assign o_free      = !o_valid || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_hit;
        end else if (o_valid && i_ready) begin
            r_mask <= s_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_info <= i_info;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_mask == '0 || ($onehot(r_mask) && i_ready)))
        else $error("new mask loaded over pending seeds");

    a_burst_goes_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("seed burst ended before its last seed");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> $onehot(r_mask))
        else $error("last flag with more than one seed pending");

endmodule

// File: src/kmer_exact_match_seeder.sv
// k-mer exact match seeder: input register, parallel read cells, seed emitter
// One item is taken per clock while the seed emitter is free. Load, clear
// and genome characters that cause no seed pass straight through; a genome
// character whose k-long diagonal matches end at n read positions sends n
// seeds (n up to READ_LEN), one per cycle while the receiver is ready, and
// holds the input side as the single-entry seed emitter drains. The next
// item is taken in the cycle the last seed of the current one is taken.
// All read positions compare against the genome character at once.
module kmer_exact_match_seeder
    import kems_pkg::*;
#(
    parameter int READ_LEN = READ_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CDATA_W-1:0]  i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // read_index, symbol, 2'b0
    input  logic [OP_W-1:0]     s_axis_tuser,   // opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // seed read position, seed genome position, 2'b0
    output logic                m_axis_tlast
);

    logic [KMER_W-1:0] r_kmer_len;
    logic [RLEN_W-1:0] r_read_len;

    logic              r_in_valid;
    t_opcode           r_op;
    logic [RIDX_W-1:0] r_idx;
    logic [SYM_W-1:0]  r_sym;

    logic                s_advance;
    logic                s_free;
    logic [READ_LEN-1:0] s_hit;
    t_batch_info         s_info;
    logic [RIDX_W-1:0]   s_seed_ridx;
    logic [POS_W-1:0]    s_seed_gpos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= KMER_RST;
            r_read_len <= RLEN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KMER_LEN: r_kmer_len <= KMER_W'(i_cfg_data);
                CFG_READ_LEN: r_read_len <= RLEN_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign s_advance     = r_in_valid && s_free;
    assign s_axis_tready = !r_in_valid || s_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= t_opcode'(s_axis_tuser);
            r_idx <= s_axis_tdata[RIDX_W-1:0];
            r_sym <= s_axis_tdata[RIDX_W+SYM_W-1:RIDX_W];
        end
    end

    kems_cells #(
        .READ_LEN (READ_LEN)
    ) u_cells (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kmer_len   (r_kmer_len),
        .i_read_len   (r_read_len),
        .i_go         (s_advance),
        .i_opcode     (r_op),
        .i_read_index (r_idx),
        .i_symbol     (r_sym),
        .o_hit        (s_hit),
        .o_info       (s_info)
    );

    kems_emit #(
        .READ_LEN (READ_LEN)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_advance),
        .i_hit       (s_hit),
        .i_info      (s_info),
        .o_free      (s_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_seed_ridx (s_seed_ridx),
        .o_seed_gpos (s_seed_gpos),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, s_seed_gpos, s_seed_ridx};

endmodule

// File: bench/tb_kmer_exact_match_seeder.sv
// testbench for the k-mer exact match seeder: predicted seeds checked against the result stream
module tb_kmer_exact_match_seeder;
    import kems_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 6;
    localparam int TILE_LEN      = READ_LEN_DEF;

    localparam logic [31:0] BASE_CHARS = "ACGT";
    localparam logic [SYM_W-1:0] CASE_BIT = CASE_DELTA[SYM_W-1:0];
    localparam logic [SYM_W-1:0] LOWER_A = 8'h61;
    localparam logic [SYM_W-1:0] UPPER_A = 8'h41;
    localparam logic [SYM_W-1:0] LOWER_B = 8'h62;

    // read cells and genome probes around the case-gap rule, non-letters included
    localparam logic [SYM_W-1:0] CASE_CELLS [10] = '{8'h00, 8'h20, 8'h40, 8'hFF, 8'hDF,
                                                    8'hBF, 8'h41, 8'h61, 8'h21, 8'h80};
    localparam logic [SYM_W-1:0] CASE_PROBES [8] = '{8'h20, 8'h00, 8'hDF, 8'hFF,
                                                     8'h60, 8'hA0, 8'h01, 8'h61};

    typedef struct packed {
        logic [RIDX_W-1:0] ridx;
        logic [POS_W-1:0]  gpos;
        logic              seed_last;
    } t_seed;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CIDX_W-1:0]  i_cfg_idx     = '0;
    logic [CDATA_W-1:0] i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;   // read_index, symbol, 2'b0
    logic [OP_W-1:0]    s_axis_tuser  = '0;   // opcode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;         // seed read position, seed genome position, 2'b0
    logic               m_axis_tlast;

    // predicted block state
    logic [SYM_W-1:0]  read_tile [TILE_LEN];
    logic [RUN_W-1:0]  run_len [TILE_LEN];
    logic [POS_W-1:0]  genome_pos;
    logic [KMER_W-1:0] kmer_cfg;
    logic [RLEN_W-1:0] rlen_cfg;
    t_seed             seeds_due [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int idle_mode      = 0;   // 0: sender 22 / receiver 45, 1: swapped, 2: no idling

    kmer_exact_match_seeder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("kmer_exact_match_seeder verification failed");
            $finish;
        end
    end

    function automatic bit chars_match(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
        int ia;
        int ib;
        ia = int'(a);
        ib = int'(b);
        return ia == ib || ia + int'(CASE_DELTA) == ib || ib + int'(CASE_DELTA) == ia;
    endfunction

    function automatic logic [SYM_W-1:0] random_base();
        logic [SYM_W-1:0] b;
        b = BASE_CHARS[8 * $urandom_range(3) +: 8];
        return $urandom_range(1) ? (b | CASE_BIT) : b;
    endfunction

    function automatic logic [SYM_W-1:0] case_flip(logic [SYM_W-1:0] c);
        return $urandom_range(1) ? (c ^ CASE_BIT) : c;
    endfunction

    // diagonal run update over all read cells, seeds queued in rising read order
    task automatic predict_item(t_opcode op, logic [RIDX_W-1:0] idx, logic [SYM_W-1:0] sym);
        int k;
        int used;
        int hits;
        int seen;
        int r;
        logic [RUN_W-1:0] nxt [TILE_LEN];
        t_seed s;
        case (op)
            OP_LOAD: begin
                read_tile[idx] = sym;
            end
            OP_CLEAR: begin
                foreach (run_len[i]) run_len[i] = '0;
                genome_pos = '0;
            end
            OP_GENOME: begin
                k = (kmer_cfg == 0) ? 1 : (kmer_cfg > KMER_MAX) ? int'(KMER_MAX) : int'(kmer_cfg);
                used = (int'(rlen_cfg) > TILE_LEN) ? TILE_LEN : int'(rlen_cfg);
                hits = 0;
                for (int i = 0; i < TILE_LEN; i++) begin
                    r = 0;
                    if (i < used && chars_match(read_tile[i], sym)) begin
                        r = ((i == 0) ? 0 : int'(run_len[i-1])) + 1;
                        if (r > k) r = k;
                    end
                    nxt[i] = RUN_W'(r);
                    if (r >= k) hits++;
                end
                seen = 0;
                for (int i = 0; i < TILE_LEN; i++) begin
                    if (int'(nxt[i]) >= k) begin
                        seen++;
                        s.ridx      = RIDX_W'(i + 1 - k);
                        s.gpos      = genome_pos - POS_W'(k - 1);
                        s.seed_last = (seen == hits);
                        seeds_due   = {seeds_due, s};
                    end
                end
                run_len = nxt;
                genome_pos = genome_pos + POS_W'(1);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        $display("seed check error (%s): expected 0x%0h, got 0x%0h at cycle %0d",
                 what, want, got, cycle_count);
        mismatch_count++;
    endtask

    // result side: compare each taken seed with the oldest prediction, then pick next ready
    always @(posedge i_clk) begin
        t_seed want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (seeds_due.size() == 0) begin
                report_mismatch("seed with none expected", 0, m_axis_tdata);
            end else begin
                want = seeds_due.pop_front();
                if (m_axis_tdata[5:0] !== want.ridx)
                    report_mismatch("read position", want.ridx, m_axis_tdata[5:0]);
                if (m_axis_tdata[37:6] !== want.gpos)
                    report_mismatch("genome position", want.gpos, m_axis_tdata[37:6]);
                if (m_axis_tlast !== want.seed_last)
                    report_mismatch("seed_last", want.seed_last, m_axis_tlast);
            end
        end
        case (idle_mode)
            0: m_axis_tready <= ($urandom_range(99) >= 45);
            1: m_axis_tready <= ($urandom_range(99) >= 22);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // one request on the input side; returns at the edge where it was taken
    task automatic send_item(t_opcode op, logic [RIDX_W-1:0] idx, logic [SYM_W-1:0] sym);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 45 : 0;
        // each cycle idles with the given chance
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, sym, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(op, idx, sym);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (seeds_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CDATA_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KMER_LEN) kmer_cfg = value;
        else rlen_cfg = value;
    endtask

    // genome characters copied from the tile along one diagonal, case scrambled
    task automatic stream_copy(int from, int n);
        for (int j = 0; j < n; j++)
            send_item(OP_GENOME, RIDX_W'($urandom), case_flip(read_tile[(from + j) % TILE_LEN]));
    endtask

    // default k over all cells, then runs saturated at 16 keep growing to k of 64
    task automatic test_reset_defaults();
        for (int i = 0; i < TILE_LEN; i++)
            send_item(OP_LOAD, RIDX_W'(i), case_flip(LOWER_A));
        for (int j = 0; j < 16; j++)
            send_item(OP_GENOME, RIDX_W'($urandom), case_flip(UPPER_A));
        write_cfg(CFG_KMER_LEN, 7'd100);
        for (int j = 0; j < 48; j++)
            send_item(OP_GENOME, RIDX_W'($urandom), case_flip(LOWER_A));
        write_cfg(CFG_KMER_LEN, 7'd127);
        send_item(OP_GENOME, '0, UPPER_A);
        send_item(OP_NONE, 6'h3F, 8'hFF);
        send_item(OP_CLEAR, '0, '0);
    endtask

    // every cell holds a or A: each a or A at k of 1 seeds from every cell, b from none
    task automatic test_max_burst();
        write_cfg(CFG_KMER_LEN, 7'd0);
        send_item(OP_GENOME, '0, UPPER_A);
        send_item(OP_GENOME, 6'h3F, LOWER_A);
        send_item(OP_GENOME, '0, LOWER_B);
        send_item(OP_GENOME, '0, UPPER_A);
        write_cfg(CFG_KMER_LEN, 7'd1);
        send_item(OP_GENOME, '0, LOWER_A);
        write_cfg(CFG_KMER_LEN, 7'd2);
        send_item(OP_GENOME, '0, UPPER_A);
        send_item(OP_GENOME, '0, UPPER_A);
    endtask

    task automatic test_case_rule();
        write_cfg(CFG_KMER_LEN, 7'd1);
        write_cfg(CFG_READ_LEN, 7'd10);
        for (int i = 0; i < 10; i++) send_item(OP_LOAD, RIDX_W'(i), CASE_CELLS[i]);
        for (int i = 0; i < 8; i++) send_item(OP_GENOME, RIDX_W'($urandom), CASE_PROBES[i]);
    endtask

    task automatic test_read_len();
        write_cfg(CFG_READ_LEN, 7'd0);
        send_item(OP_GENOME, '0, LOWER_A);
        send_item(OP_GENOME, '0, UPPER_A);
        write_cfg(CFG_READ_LEN, 7'd100);
        send_item(OP_GENOME, '0, UPPER_A);
        write_cfg(CFG_READ_LEN, 7'd37);
        send_item(OP_GENOME, '0, LOWER_A);
        write_cfg(CFG_READ_LEN, 7'd64);
    endtask

    task automatic test_clear();
        write_cfg(CFG_KMER_LEN, 7'd4);
        send_item(OP_CLEAR, '0, '0);
        stream_copy(5, 5);
        send_item(OP_CLEAR, 6'h3F, 8'hFF);
        stream_copy(8, 4);
        // a load mid-stream leaves runs and position alone
        send_item(OP_LOAD, 6'd20, random_base());
        stream_copy(12, 3);
    endtask

    task automatic run_random(int n_items);
        int sent;
        int ptr;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 40) begin
                pick = $urandom_range(99);
                write_cfg(CFG_KMER_LEN, CDATA_W'((pick < 70) ? $urandom_range(1, 8) :
                                        (pick < 90) ? $urandom_range(9, 24) : $urandom_range(127)));
                pick = $urandom_range(99);
                write_cfg(CFG_READ_LEN, CDATA_W'((pick < 60) ? 64 :
                                        (pick < 90) ? $urandom_range(1, 63) : $urandom_range(127)));
            end else if ($urandom_range(99) < 30) begin
                wait_drained();
            end
            repeat ($urandom_range(2)) begin
                send_item(OP_LOAD, RIDX_W'($urandom),
                          ($urandom_range(99) < 80) ? random_base() : SYM_W'($urandom));
                sent++;
            end
            ptr = $urandom_range(TILE_LEN - 1);
            repeat ($urandom_range(3, 10)) begin
                pick = $urandom_range(99);
                if (pick < 72) begin
                    send_item(OP_GENOME, RIDX_W'($urandom), case_flip(read_tile[ptr]));
                    ptr = ($urandom_range(99) < 8) ? $urandom_range(TILE_LEN - 1)
                                                   : (ptr + 1) % TILE_LEN;
                end else if (pick < 82) begin
                    send_item(OP_GENOME, RIDX_W'($urandom), SYM_W'($urandom));
                end else if (pick < 92) begin
                    send_item(OP_GENOME, RIDX_W'($urandom), random_base());
                end else if (pick < 95) begin
                    send_item(OP_CLEAR, RIDX_W'($urandom), SYM_W'($urandom));
                end else if (pick < 97) begin
                    send_item(OP_NONE, RIDX_W'($urandom), SYM_W'($urandom));
                end else begin
                    send_item(OP_LOAD, RIDX_W'($urandom), random_base());
                end
                sent++;
            end
        end
    endtask

    initial begin
        foreach (run_len[i]) run_len[i] = '0;
        genome_pos = '0;
        kmer_cfg   = KMER_RST;
        rlen_cfg   = RLEN_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_max_burst();
        idle_mode = 1;
        test_case_rule();
        test_read_len();
        test_clear();
        idle_mode = 2;
        run_random(8);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("kmer_exact_match_seeder verification clean");
        end else begin
            $display("kmer_exact_match_seeder verification failed");
        end
        $finish;
    end

endmodule
